// ===== src/assert_macros.svh =====
// Assertion macros for the motor speed regulator RTL.
// Uses the enclosing module's clk and arst_n; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
`define ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMP(label, ante, cons)
`define ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== src/dmpi_pkg.sv =====
// Types and constants for the dual-motor incremental PI speed regulator.
// No dependencies; imported by the top level.
`default_nettype none

package dmpi_pkg;

	// field widths
	localparam int ENC_W   = 16;
	localparam int TGT_W   = 24;
	localparam int GAIN_W  = 16;
	localparam int DUTY_W  = 14;
	localparam int PER_W   = 10;
	localparam int PPR_W   = 16;
	localparam int PPS_W   = 26;
	localparam int RPM_W   = 32;
	localparam int TOT_W   = 32;

	// internal datapath widths
	localparam int CNT_W   = 18;             // signed count, up to +/-65535
	localparam int SPD_W   = 27;             // full signed pulses per second
	localparam int ERR_W   = 28;
	localparam int DIFF_W  = 29;
	localparam int MA_W    = 30;             // signed multiplier operand
	localparam int PROD_W  = MA_W + GAIN_W + 1;
	localparam int ACC_W   = PROD_W + 1;
	localparam int STEP_W  = ACC_W - 8;
	localparam int DRV_W   = 15;
	localparam int DSUM_W  = STEP_W + 1;
	localparam int DIV_W   = 32;
	localparam int REM_W   = PPR_W + 1;
	localparam int DCNT_W  = 5;

	// port widths
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W  = TGT_W + ENC_W;
	localparam int IN_USER_W  = 2;
	localparam int OUT_USED_W = DUTY_W + 2 + PPS_W + RPM_W + 2 * TOT_W;
	localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

	// scale constants
	localparam logic [GAIN_W-1:0] PPS_SCALE = 16'd1000;   // ms to s
	localparam logic [GAIN_W-1:0] RPM_SCALE = 16'd60;     // s to min

	// register reset values
	localparam logic [GAIN_W-1:0] KP_RST   = 16'd256;
	localparam logic [GAIN_W-1:0] KI_RST   = 16'd256;
	localparam logic [DUTY_W-1:0] DUTY_RST = 14'd8399;
	localparam logic [PER_W-1:0]  PER_RST  = 10'd10;
	localparam logic [PPR_W-1:0]  PPR_RST  = 16'd1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP,
		REG_KI,
		REG_MAX_DUTY,
		REG_PERIOD,
		REG_PPR
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MPPS,   // count * 1000
		S_LPPS,   // load divider, period
		S_DPPS,   // divide by period
		S_FIXP,   // sign pps
		S_MRPM,   // pps * 60, error and error change
		S_LRPM,   // load divider, pulses per rev
		S_DRPM,   // divide by pulses per rev
		S_MKP,    // kp * error change
		S_MKI,    // ki * error
		S_STEP,   // sum and scale by 1/256
		S_UPD     // clamp, update state, load output
	} state_t;

endpackage

`default_nettype wire

// ===== src/dual_motor_incremental_pi_speed.sv =====
// A tick beat is accepted in S_IDLE and runs through the sequencer states to S_UPD, which
// loads the output register; one tick in flight at a time, so the next beat is taken only
// after S_UPD returns to S_IDLE. The two 32-step restoring divisions on the shared divider
// take up most of a tick's run. Set beats are likewise taken only in S_IDLE.
// Input is not ready while a tick is in work; a finished result waits in the output
// register and the next beat is accepted meanwhile.
// arst_n (async, active low) clears registers to defaults and per-motor state to zero.
`default_nettype none

`include "assert_macros.svh"

module dual_motor_incremental_pi_speed #(
	parameter int COUNTER_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// target_speed[23:0], encoder_count[39:24]
	input  logic [dmpi_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// action[0], motor[1]
	input  logic [dmpi_pkg::IN_USER_W-1:0]   s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// duty[13:0], pin_a[14], pin_b[15], speed_pps[41:16], speed_rpm[73:42],
	// abs_total[105:74], net_total[137:106], zero[143:138]
	output logic [dmpi_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// motor_out[0]
	output logic [0:0]                       m_axis_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dmpi_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dmpi_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import dmpi_pkg::*;

	localparam int EB = (COUNTER_BITS < ENC_W) ? COUNTER_BITS : ENC_W;

	state_t state_q, state_d;
	logic [DCNT_W-1:0] dcnt_q;

	logic [GAIN_W-1:0] kp_q, ki_q;
	logic [DUTY_W-1:0] maxd_q;
	logic [PER_W-1:0]  per_q;
	logic [PPR_W-1:0]  ppr_q;

	logic signed [TGT_W-1:0] tgt_q   [2];
	logic signed [DRV_W-1:0] drive_q [2];
	logic signed [ERR_W-1:0] prev_q  [2];
	logic [TOT_W-1:0]        abs_q   [2];
	logic [TOT_W-1:0]        net_q   [2];

	logic                     motor_q;
	logic signed [CNT_W-1:0]  cnt_q;
	logic signed [PROD_W-1:0] prod_q, acc_q;
	logic [DIV_W-1:0]         quo_q;
	logic [REM_W-1:0]         rem_q;
	logic [PPR_W-1:0]         div_q;
	logic                     neg_q;
	logic signed [SPD_W-1:0]  pps_q;
	logic signed [ERR_W-1:0]  err_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic [RPM_W-1:0]         rpm_q;
	logic signed [STEP_W-1:0] step_q;

	logic              ov_q, omotor_q, pa_q, pb_q;
	logic [DUTY_W-1:0] duty_q;
	logic [PPS_W-1:0]  opps_q;
	logic [RPM_W-1:0]  orpm_q;
	logic [TOT_W-1:0]  oabs_q, onet_q;

	// input decode
	logic                    in_acc, tick_acc, in_action, in_motor, enc_sign;
	logic [EB-1:0]           enc_bits;
	logic signed [CNT_W-1:0] cnt_raw, cnt_in;

	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign in_action = s_axis_tuser[0];
	assign in_motor  = s_axis_tuser[1];
	assign tick_acc  = in_acc && in_action;
	assign enc_bits  = s_axis_tdata[TGT_W +: EB];
	assign enc_sign  = (COUNTER_BITS <= ENC_W) ? enc_bits[EB-1] : 1'b0;
	assign cnt_raw   = $signed({{(CNT_W - EB){enc_sign}}, enc_bits});
	assign cnt_in    = in_motor ? -cnt_raw : cnt_raw;

	// shared multiplier
	logic signed [MA_W-1:0]   mul_a;
	logic [GAIN_W-1:0]        mul_b;
	logic signed [PROD_W-1:0] mul_p;

	always_comb begin
		case (state_q)
			S_MPPS: begin
				mul_a = MA_W'(cnt_q);
				mul_b = PPS_SCALE;
			end
			S_MRPM: begin
				mul_a = MA_W'(pps_q);
				mul_b = RPM_SCALE;
			end
			S_MKP: begin
				mul_a = MA_W'(diff_q);
				mul_b = kp_q;
			end
			S_MKI: begin
				mul_a = MA_W'(err_q);
				mul_b = ki_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * $signed({1'b0, mul_b});

	// shared restoring divider, one quotient bit per cycle on magnitudes
	logic [REM_W-1:0]         rem_sh, rem_n, div_ext;
	logic                     div_ge;
	logic signed [PROD_W-1:0] prod_abs;
	logic [DIV_W-1:0]         quo_sgn;

	assign div_ext  = {1'b0, div_q};
	assign rem_sh   = {rem_q[REM_W-2:0], quo_q[DIV_W-1]};
	assign div_ge   = rem_sh >= div_ext;
	assign rem_n    = div_ge ? rem_sh - div_ext : rem_sh;
	assign prod_abs = prod_q[PROD_W-1] ? -prod_q : prod_q;
	assign quo_sgn  = neg_q ? -quo_q : quo_q;

	// error and PI step
	logic signed [SPD_W-1:0]  pps_n;
	logic signed [ERR_W-1:0]  err_d;
	logic signed [DIFF_W-1:0] diff_d;
	logic signed [ACC_W-1:0]  pi_sum, pi_adj;

	assign pps_n  = $signed(quo_sgn[SPD_W-1:0]);
	assign err_d  = ERR_W'(tgt_q[motor_q]) - ERR_W'(pps_q);
	assign diff_d = DIFF_W'(err_d) - DIFF_W'(prev_q[motor_q]);
	assign pi_sum = ACC_W'(acc_q) + ACC_W'(prod_q);
	// bias negative sums so the shift truncates toward zero
	assign pi_adj = pi_sum + (pi_sum[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));

	// clamp and outputs
	logic signed [DSUM_W-1:0] dsum, lim, dclamp;
	logic signed [DRV_W-1:0]  drv_new;
	logic [DRV_W-1:0]         drv_abs;
	logic [DUTY_W-1:0]        duty_new;
	logic                     rev, pa_new, pb_new, out_free, out_acc;
	logic signed [CNT_W-1:0]  cnt_abs;
	logic [TOT_W-1:0]         abs_new, net_new;

	assign dsum   = DSUM_W'(drive_q[motor_q]) + DSUM_W'(step_q);
	assign lim    = $signed({{(DSUM_W - DUTY_W){1'b0}}, maxd_q});

	always_comb begin
		if (dsum > lim) begin
			dclamp = lim;
		end else if (dsum < -lim) begin
			dclamp = -lim;
		end else begin
			dclamp = dsum;
		end
	end

	assign drv_new  = DRV_W'(dclamp);
	assign drv_abs  = drv_new[DRV_W-1] ? $unsigned(-drv_new) : $unsigned(drv_new);
	assign duty_new = drv_abs[DUTY_W-1:0];
	assign rev      = drv_new[DRV_W-1];
	// right motor: A reverse, B forward; left motor swapped
	assign pa_new   = (duty_new != '0) && (rev ^ motor_q);
	assign pb_new   = (duty_new != '0) && !(rev ^ motor_q);
	assign cnt_abs  = cnt_q[CNT_W-1] ? -cnt_q : cnt_q;
	assign abs_new  = abs_q[motor_q] + TOT_W'($unsigned(cnt_abs));
	assign net_new  = net_q[motor_q] + $unsigned(TOT_W'(cnt_q));
	assign out_free = !ov_q || m_axis_tready;
	assign out_acc  = ov_q && m_axis_tready;

	// sequencer
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (tick_acc) begin
					state_d = S_MPPS;
				end
			end
			S_MPPS: state_d = S_LPPS;
			S_LPPS: state_d = S_DPPS;
			S_DPPS: begin
				if (dcnt_q == '1) begin
					state_d = S_FIXP;
				end
			end
			S_FIXP: state_d = S_MRPM;
			S_MRPM: state_d = S_LRPM;
			S_LRPM: state_d = S_DRPM;
			S_DRPM: begin
				if (dcnt_q == '1) begin
					state_d = S_MKP;
				end
			end
			S_MKP:  state_d = S_MKI;
			S_MKI:  state_d = S_STEP;
			S_STEP: state_d = S_UPD;
			S_UPD: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cfg_ready = 1'b1;

	// control, configuration and per-motor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
			ov_q   <= 1'b0;
			rem_q  <= '0;
			div_q  <= PPR_W'(1);
			kp_q   <= KP_RST;
			ki_q   <= KI_RST;
			maxd_q <= DUTY_RST;
			per_q  <= PER_RST;
			ppr_q  <= PPR_RST;
			for (int i = 0; i < 2; i++) begin
				tgt_q[i]   <= '0;
				drive_q[i] <= '0;
				prev_q[i]  <= '0;
				abs_q[i]   <= '0;
				net_q[i]   <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_KP:       kp_q   <= cfg_data;
					REG_KI:       ki_q   <= cfg_data;
					REG_MAX_DUTY: maxd_q <= cfg_data[DUTY_W-1:0];
					REG_PERIOD:   per_q  <= cfg_data[PER_W-1:0];
					REG_PPR:      ppr_q  <= cfg_data[PPR_W-1:0];
					default: ;
				endcase
			end
			if (in_acc && !in_action) begin
				tgt_q[in_motor] <= $signed(s_axis_tdata[TGT_W-1:0]);
			end
			case (state_q)
				S_LPPS: begin
					dcnt_q <= '0;
					rem_q  <= '0;
					div_q  <= (per_q == '0) ? PPR_W'(1) : PPR_W'(per_q);
				end
				S_LRPM: begin
					dcnt_q <= '0;
					rem_q  <= '0;
					div_q  <= (ppr_q == '0) ? PPR_W'(1) : ppr_q;
				end
				S_DPPS, S_DRPM: begin
					dcnt_q <= dcnt_q + DCNT_W'(1);
					rem_q  <= rem_n;
				end
				default: ;
			endcase
			if (state_q == S_UPD && out_free) begin
				drive_q[motor_q] <= drv_new;
				prev_q[motor_q]  <= err_q;
				abs_q[motor_q]   <= abs_new;
				net_q[motor_q]   <= net_new;
				ov_q             <= 1'b1;
			end else if (out_acc) begin
				ov_q <= 1'b0;
			end
		end
	end

	// datapath payload
	always_ff @(posedge clk) begin
		if (tick_acc) begin
			motor_q <= in_motor;
			cnt_q   <= cnt_in;
		end
		case (state_q)
			S_MPPS: prod_q <= mul_p;
			S_LPPS, S_LRPM: begin
				quo_q <= prod_abs[DIV_W-1:0];
				neg_q <= prod_q[PROD_W-1];
			end
			S_DPPS, S_DRPM: quo_q <= {quo_q[DIV_W-2:0], div_ge};
			S_FIXP: pps_q <= pps_n;
			S_MRPM: begin
				err_q  <= err_d;
				diff_q <= diff_d;
				prod_q <= mul_p;
			end
			S_MKP: begin
				rpm_q  <= quo_sgn;
				prod_q <= mul_p;
			end
			// kp product moves to the accumulator, ki product takes its place
			S_MKI: begin
				acc_q  <= prod_q;
				prod_q <= mul_p;
			end
			S_STEP: step_q <= pi_adj[ACC_W-1:8];
			default: ;
		endcase
		if (state_q == S_UPD && out_free) begin
			omotor_q <= motor_q;
			duty_q   <= duty_new;
			pa_q     <= pa_new;
			pb_q     <= pb_new;
			opps_q   <= pps_q[PPS_W-1:0];
			orpm_q   <= rpm_q;
			oabs_q   <= abs_new;
			onet_q   <= net_new;
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tuser  = omotor_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, onet_q, oabs_q, orpm_q, opps_q,
		pb_q, pa_q, duty_q};

	`ASSERT_IMP(a_pins_excl, m_axis_tvalid, !(pa_q && pb_q))
	`ASSERT_IMP(a_duty_pins, m_axis_tvalid, (duty_q == '0) == (!pa_q && !pb_q))
	`ASSERT_NXT(a_upd_out, state_q == S_UPD && out_free, m_axis_tvalid && s_axis_tready)
	`ASSERT_IMP(a_rem_lt_div, state_q == S_DPPS || state_q == S_DRPM, rem_q < div_ext)

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Testbench for dual_motor_incremental_pi_speed: randomized set/tick streams over
// several register settings, checked against an in-bench PI regulator model.
// Depends on dmpi_pkg and the RTL top level only.

module tb;
	import dmpi_pkg::*;

	localparam logic ACT_SET     = 1'b0;
	localparam logic ACT_TICK    = 1'b1;
	localparam logic SIDE_RIGHT  = 1'b0;
	localparam logic SIDE_LEFT   = 1'b1;

	localparam int RESET_CYCLES = 10;
	localparam int SETTLE_CYCLES = 100;   // longer than the run of one tick through the block
	localparam int STALL_CYCLES = 400;
	localparam int WDOG_LIMIT = 5000;
	localparam int MAX_PRINTS = 100;

	typedef struct {
		logic             action;
		logic             motor;
		logic [TGT_W-1:0] target;
		logic [ENC_W-1:0] enc;
	} motor_cmd_t;

	typedef struct {
		logic              motor;
		logic [DUTY_W-1:0] duty;
		logic              pin_a;
		logic              pin_b;
		logic [PPS_W-1:0]  pps;
		logic [RPM_W-1:0]  rpm;
		logic [TOT_W-1:0]  abs_tot;
		logic [TOT_W-1:0]  net_tot;
	} drive_result_t;

	// first member is the top of the word
	typedef struct packed {
		logic [OUT_PAD_W-1:0] pad;
		logic [TOT_W-1:0]     net_tot;
		logic [TOT_W-1:0]     abs_tot;
		logic [RPM_W-1:0]     rpm;
		logic [PPS_W-1:0]     pps;
		logic                 pin_b;
		logic                 pin_a;
		logic [DUTY_W-1:0]    duty;
	} out_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic [IN_USER_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [0:0] m_axis_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	dual_motor_incremental_pi_speed uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #6 clk = ~clk;

	// register shadows
	logic [GAIN_W-1:0] kp_reg = KP_RST;
	logic [GAIN_W-1:0] ki_reg = KI_RST;
	logic [DUTY_W-1:0] duty_lim = DUTY_RST;
	logic [PER_W-1:0]  period_reg = PER_RST;
	logic [PPR_W-1:0]  ppr_reg = PPR_RST;

	// per-motor regulator state
	logic signed [TGT_W-1:0] target_st [2] = '{default: '0};
	logic signed [DRV_W-1:0] drive_st [2] = '{default: '0};
	logic signed [31:0]      prev_err [2] = '{default: '0};
	logic [TOT_W-1:0]        abs_acc [2] = '{default: '0};
	logic [TOT_W-1:0]        net_acc [2] = '{default: '0};

	motor_cmd_t    cmd_q[$];
	drive_result_t drive_result_q[$];

	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	int  mismatches = 0;
	int  result_count = 0;
	int  quiet_cycles = 0;
	logic in_taken = 1'b0;
	logic rx_hold = 1'b0;
	logic stall_arm = 1'b0;

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("ERROR at %0t: result %0d: %s", $time, result_count, msg);
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
	endtask

	// One command through the velocity-form PI regulator; ticks queue a result.
	function automatic void regulate_step(input logic act, input logic mot,
			input logic [TGT_W-1:0] tgt, input logic [ENC_W-1:0] enc);
		int m;
		longint c, mag, per, ppr, pps, rpm, err, stp, dv, lim, kg, ig;
		drive_result_t r;
		m = mot;
		if (act == ACT_SET) begin
			target_st[m] = tgt;
			return;
		end
		c = $signed(enc);
		if (mot == SIDE_LEFT)
			c = -c;
		// a zero divisor acts as one
		per = period_reg;
		if (per == 0)
			per = 1;
		ppr = ppr_reg;
		if (ppr == 0)
			ppr = 1;
		pps = (c * 1000) / per;
		rpm = (pps * 60) / ppr;
		mag = (c < 0) ? -c : c;
		abs_acc[m] = abs_acc[m] + mag[31:0];
		net_acc[m] = net_acc[m] + c[31:0];
		kg = kp_reg;
		ig = ki_reg;
		err = target_st[m] - pps;
		stp = (kg * (err - prev_err[m]) + ig * err) / 256;
		prev_err[m] = err[31:0];
		lim = duty_lim;
		dv = drive_st[m] + stp;
		if (dv > lim)
			dv = lim;
		if (dv < -lim)
			dv = -lim;
		drive_st[m] = dv[DRV_W-1:0];
		mag = (dv < 0) ? -dv : dv;
		r.motor = mot;
		r.duty = mag[DUTY_W-1:0];
		r.pin_a = 1'b0;
		r.pin_b = 1'b0;
		if (mag != 0) begin
			// pins swap meaning between the two motors
			r.pin_a = (dv < 0) ^ (mot == SIDE_LEFT);
			r.pin_b = !r.pin_a;
		end
		r.pps = pps[PPS_W-1:0];
		r.rpm = rpm[RPM_W-1:0];
		r.abs_tot = abs_acc[m];
		r.net_tot = net_acc[m];
		drive_result_q.push_back(r);
	endfunction

	// input driver
	always @(negedge clk) begin : drive_in
		motor_cmd_t cmd;
		if (arst_n && (!s_axis_tvalid || in_taken)) begin
			if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cmd = cmd_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {cmd.enc, cmd.target};
				s_axis_tuser <= {cmd.motor, cmd.action};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result receiver
	always @(negedge clk)
		m_axis_tready <= arst_n && !rx_hold && ($urandom_range(99) >= recv_idle_pct);

	// long receiver hold-off so the block backs up and stalls its input
	initial begin : stall_proc
		wait (stall_arm);
		@(negedge clk) rx_hold <= 1'b1;
		repeat (STALL_CYCLES) @(negedge clk);
		rx_hold <= 1'b0;
	end

	// monitor: check results, then track register writes and accepted commands
	always @(posedge clk) begin : monitor
		out_word_t got;
		drive_result_t want;
		in_taken <= s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (drive_result_q.size() == 0) begin
					report_mismatch("result beat with nothing expected");
				end else begin
					want = drive_result_q.pop_front();
					check_field("motor_out", 64'(m_axis_tuser), 64'(want.motor));
					check_field("duty", 64'(got.duty), 64'(want.duty));
					check_field("pin_a", 64'(got.pin_a), 64'(want.pin_a));
					check_field("pin_b", 64'(got.pin_b), 64'(want.pin_b));
					check_field("speed_pps", 64'(got.pps), 64'(want.pps));
					check_field("speed_rpm", 64'(got.rpm), 64'(want.rpm));
					check_field("abs_total", 64'(got.abs_tot), 64'(want.abs_tot));
					check_field("net_total", 64'(got.net_tot), 64'(want.net_tot));
					check_field("pad", 64'(got.pad), '0);
				end
				result_count++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_KP:       kp_reg = cfg_data;
					REG_KI:       ki_reg = cfg_data;
					REG_MAX_DUTY: duty_lim = cfg_data[DUTY_W-1:0];
					REG_PERIOD:   period_reg = cfg_data[PER_W-1:0];
					REG_PPR:      ppr_reg = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				regulate_step(s_axis_tuser[0], s_axis_tuser[1],
					s_axis_tdata[TGT_W-1:0], s_axis_tdata[TGT_W +: ENC_W]);
		end
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(input logic [15:0] kp, input logic [15:0] ki,
			input logic [15:0] maxd, input logic [15:0] per, input logic [15:0] ppr);
		write_reg(REG_KP, kp);
		write_reg(REG_KI, ki);
		write_reg(REG_MAX_DUTY, maxd);
		write_reg(REG_PERIOD, per);
		write_reg(REG_PPR, ppr);
	endtask

	function automatic void push_cmd(input logic act, input logic mot, input int tgt,
			input logic [ENC_W-1:0] enc);
		motor_cmd_t c;
		c.action = act;
		c.motor = mot;
		c.target = tgt[TGT_W-1:0];
		c.enc = enc;
		cmd_q.push_back(c);
	endfunction

	// mostly ticks around realistic speeds, some full-range and corner values
	function automatic void push_random_cmd();
		int tgt;
		logic [ENC_W-1:0] enc;
		logic [ENC_W-1:0] enc_corner [5];
		enc_corner = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF};
		case ($urandom_range(9))
			0: tgt = int'($urandom_range(16777214)) - 8388607;
			1: tgt = ($urandom_range(1) != 0) ? 8388607 : -8388607;
			2: tgt = 0;
			default: tgt = int'($urandom_range(100000)) - 50000;
		endcase
		case ($urandom_range(9))
			0, 1, 2: enc = ENC_W'($urandom());
			3: enc = enc_corner[$urandom_range(4)];
			default: enc = 16'(int'($urandom_range(600)) - 300);
		endcase
		push_cmd(($urandom_range(99) < 80) ? ACT_TICK : ACT_SET, 1'($urandom_range(1)),
			tgt, enc);
	endfunction

	task automatic drain();
		while (cmd_q.size() != 0 || s_axis_tvalid || drive_result_q.size() != 0)
			@(negedge clk);
		// set beats leave no result behind, so give the block time to go idle
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input int n, input int s_pct, input int r_pct);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		@(posedge clk);
		repeat (n) push_random_cmd();
		drain();
	endtask

	initial begin : stimulus
		int s_modes [4];
		int r_modes [4];
		logic [15:0] kp, ki;
		s_modes = '{0, 83, 0, 23};
		r_modes = '{0, 0, 83, 23};
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero drive, saturation both ways, count extremes
		push_cmd(ACT_TICK, SIDE_RIGHT, 0, 16'h0000);
		push_cmd(ACT_TICK, SIDE_LEFT, 0, 16'h0000);
		push_cmd(ACT_SET, SIDE_RIGHT, 8388607, 16'hFFFF);
		push_cmd(ACT_SET, SIDE_LEFT, -8388607, 16'h0000);
		push_cmd(ACT_TICK, SIDE_RIGHT, 0, 16'h7FFF);
		push_cmd(ACT_TICK, SIDE_LEFT, 0, 16'h8000);
		push_cmd(ACT_TICK, SIDE_RIGHT, 0, 16'hFFFF);
		push_cmd(ACT_TICK, SIDE_LEFT, 0, 16'h0001);
		push_cmd(ACT_SET, SIDE_RIGHT, 0, 16'h0000);
		push_cmd(ACT_SET, SIDE_LEFT, 0, 16'h0000);
		push_cmd(ACT_TICK, SIDE_RIGHT, 0, 16'h8000);
		push_cmd(ACT_TICK, SIDE_LEFT, 0, 16'h7FFF);
		push_cmd(ACT_SET, SIDE_RIGHT, -8388607, 16'h0000);
		push_cmd(ACT_SET, SIDE_LEFT, 8388607, 16'h0000);
		push_cmd(ACT_TICK, SIDE_RIGHT, 0, 16'h1234);
		push_cmd(ACT_TICK, SIDE_LEFT, 0, 16'hEDCB);
		run_phase(200, 0, 0);

		configure(16'd0, 16'hFFFF, 16'd0, 16'd1, 16'd1);
		run_phase(200, 83, 0);

		configure(16'hFFFF, 16'd0, 16'd8399, 16'd1000, 16'hFFFF);
		run_phase(200, 0, 83);

		// zero divisors behave as one
		configure(16'd300, 16'd40, 16'd4000, 16'd0, 16'd0);
		run_phase(200, 23, 23);

		// unused indexes must not disturb any register
		configure(16'd512, 16'd128, 16'd8399, 16'd10, 16'd1000);
		for (int i = int'(REG_PPR) + 1; i < (1 << CFG_IDX_W); i++)
			write_reg(i[CFG_IDX_W-1:0], CFG_DATA_W'($urandom()));
		stall_arm = 1'b1;
		run_phase(200, 0, 0);

		for (int p = 0; p < 4; p++) begin
			kp = ($urandom_range(2) == 0) ? 16'($urandom_range(65535))
				: 16'($urandom_range(1023));
			ki = ($urandom_range(2) == 0) ? 16'($urandom_range(65535))
				: 16'($urandom_range(1023));
			configure(kp, ki, 16'($urandom_range(8399)), 16'($urandom_range(1000, 1)),
				16'($urandom_range(65535, 1)));
			run_phase(212, s_modes[p], r_modes[p]);
		end

		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
